// ===== design/sorted_sequence_merger_defines.svh =====
// Assertion helpers used by the top-level file to check this block.
`ifndef SORTED_SEQUENCE_MERGER_DEFINES_SVH
`define SORTED_SEQUENCE_MERGER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SSM_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SSM_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ssm_pkg.sv =====
package ssm_pkg;

   localparam int SEQ_DEPTH = 32;
   localparam int ADDR_W    = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
   localparam int CNT_W     = $clog2(SEQ_DEPTH + 1);
   localparam int DATA_W    = 32;
   localparam int KIND_W    = 2;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SEQ_DEPTH);

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND_FIRST  = 2'd0,
      KIND_APPEND_SECOND = 2'd1,
      KIND_MERGE         = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_PICK
   } state_type;

   typedef struct packed {
      logic              wr_first;
      logic              wr_second;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_first;
      logic [ADDR_W-1:0] rd_addr_second;
   } ram_ctl_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
      logic                     from_second;
      logic                     last;
      logic                     overflow;
   } pick_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] cnt_first;
      logic [CNT_W-1:0] cnt_second;
      logic [CNT_W-1:0] ptr_first;
      logic [CNT_W-1:0] ptr_second;
   } status_type;

endpackage

// ===== design/ssm_ram.sv =====
module ssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ssm_ctrl.sv =====
module ssm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ssm_pkg::KIND_W-1:0]    req_kind,
   input  logic [ssm_pkg::DATA_W-1:0]    rd_first,
   input  logic [ssm_pkg::DATA_W-1:0]    rd_second,
   input  logic                          out_free,
   output ssm_pkg::ram_ctl_type          ram_ctl,
   output ssm_pkg::pick_type             pick,
   output ssm_pkg::status_type           status
);

   import ssm_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_first_ff, cnt_first_in;
   logic [CNT_W-1:0] cnt_second_ff, cnt_second_in;
   logic [CNT_W-1:0] ptr_first_ff, ptr_first_in;
   logic [CNT_W-1:0] ptr_second_ff, ptr_second_in;
   logic             dropped_ff, dropped_in;
   logic             ovf_ff, ovf_in;

   logic             accept;
   logic             have_first;
   logic             have_second;
   logic             take_first;
   logic [CNT_W-1:0] ptr_first_nx;
   logic [CNT_W-1:0] ptr_second_nx;
   logic             pick_last;
   logic             any_stored;

   assign accept      = req_valid && req_ready;
   assign any_stored  = (cnt_first_ff != '0) || (cnt_second_ff != '0);
   assign have_first  = ptr_first_ff < cnt_first_ff;
   assign have_second = ptr_second_ff < cnt_second_ff;
   // A tie goes to the second sequence.
   assign take_first  = have_first &&
                        (!have_second || ($signed(rd_first) < $signed(rd_second)));
   assign ptr_first_nx  = ptr_first_ff + CNT_W'(take_first);
   assign ptr_second_nx = ptr_second_ff + CNT_W'(!take_first);
   assign pick_last     = (ptr_first_nx == cnt_first_ff) && (ptr_second_nx == cnt_second_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_MERGE) && any_stored) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (out_free) begin
               state_in = pick_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready              = 1'b0;
      ram_ctl                = '0;
      ram_ctl.wr_addr        = (req_kind == KIND_APPEND_FIRST) ?
                               cnt_first_ff[ADDR_W-1:0] : cnt_second_ff[ADDR_W-1:0];
      ram_ctl.rd_addr_first  = ptr_first_ff[ADDR_W-1:0];
      ram_ctl.rd_addr_second = ptr_second_ff[ADDR_W-1:0];
      pick.valid             = 1'b0;
      pick.value             = take_first ? $signed(rd_first) : $signed(rd_second);
      pick.from_second       = !take_first;
      pick.last              = pick_last;
      pick.overflow          = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready         = 1'b1;
            ram_ctl.wr_first  = req_valid && (req_kind == KIND_APPEND_FIRST) &&
                                (cnt_first_ff < DEPTH_CNT);
            ram_ctl.wr_second = req_valid && (req_kind == KIND_APPEND_SECOND) &&
                                (cnt_second_ff < DEPTH_CNT);
         end
         ST_READ: begin
            ram_ctl.rd_en = 1'b1;
         end
         ST_PICK: begin
            pick.valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Counters, pointers and flags.
   always_comb begin
      cnt_first_in  = cnt_first_ff;
      cnt_second_in = cnt_second_ff;
      ptr_first_in  = ptr_first_ff;
      ptr_second_in = ptr_second_ff;
      dropped_in    = dropped_ff;
      ovf_in        = ovf_ff;
      if (accept) begin
         case (req_kind)
            KIND_APPEND_FIRST: begin
               if (cnt_first_ff < DEPTH_CNT) begin
                  cnt_first_in = cnt_first_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            KIND_APPEND_SECOND: begin
               if (cnt_second_ff < DEPTH_CNT) begin
                  cnt_second_in = cnt_second_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            KIND_MERGE: begin
               ovf_in        = dropped_ff;
               dropped_in    = 1'b0;
               ptr_first_in  = '0;
               ptr_second_in = '0;
            end
            default: begin
               dropped_in = dropped_ff;
            end
         endcase
      end
      if ((state_ff == ST_PICK) && out_free) begin
         ptr_first_in  = ptr_first_nx;
         ptr_second_in = ptr_second_nx;
         if (pick_last) begin
            cnt_first_in  = '0;
            cnt_second_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_first_ff  <= '0;
         cnt_second_ff <= '0;
         ptr_first_ff  <= '0;
         ptr_second_ff <= '0;
         dropped_ff    <= 1'b0;
         ovf_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_first_ff  <= cnt_first_in;
         cnt_second_ff <= cnt_second_in;
         ptr_first_ff  <= ptr_first_in;
         ptr_second_ff <= ptr_second_in;
         dropped_ff    <= dropped_in;
         ovf_ff        <= ovf_in;
      end
   end

   assign status.busy       = state_ff != ST_IDLE;
   assign status.cnt_first  = cnt_first_ff;
   assign status.cnt_second = cnt_second_ff;
   assign status.ptr_first  = ptr_first_ff;
   assign status.ptr_second = ptr_second_ff;

endmodule

// ===== design/sorted_sequence_merger.sv =====
// Sorted sequence merger.
// The request channel carries one word per item: req_kind selects an append to the
// first sequence, an append to the second sequence, or a merge; req_value is the
// element to append and is ignored for merges. Each sequence lives in its own
// single-port-read RAM of SEQ_DEPTH entries; appends beyond that are dropped and
// raise a sticky overflow flag.
// An append produces no response. A merge walks both RAMs and emits every stored
// element in ascending order on the response channel, taking the second sequence's
// head on a tie. For each response word the block first reads both heads from the
// RAMs and then compares them and loads the output register. The final word
// carries rsp_last, and all words of a merge carry the overflow flag as it stood
// when the merge began.
// A merge of two empty sequences produces nothing but still clears the flag.
// New requests are taken only while no merge is walking the RAMs, but the next
// request is accepted while the final response word still waits in the output
// register. If the receiver stalls, the walk pauses with the next word held.
// Reset empties both sequences and clears the flag; no RAM clearing pass is needed.
`include "sorted_sequence_merger_defines.svh"

module sorted_sequence_merger (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ssm_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [ssm_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ssm_pkg::DATA_W-1:0]   rsp_merged_value,
   output logic                                rsp_from_second,
   output logic                                rsp_last,
   output logic                                rsp_overflow
);

   import ssm_pkg::*;

   ram_ctl_type              ram_ctl;
   pick_type                 pick;
   status_type               status;
   logic [DATA_W-1:0]        rd_first;
   logic [DATA_W-1:0]        rd_second;
   logic                     out_free;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] value_ff;
   logic                     from_second_ff;
   logic                     last_ff;
   logic                     overflow_ff;

   // The output register can take a new word when it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   ssm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SEQ_DEPTH)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_first),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (req_value),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.rd_addr_first),
      .rd_data (rd_first)
   );

   ssm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SEQ_DEPTH)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_second),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (req_value),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.rd_addr_second),
      .rd_data (rd_second)
   );

   ssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rd_first  (rd_first),
      .rd_second (rd_second),
      .out_free  (out_free),
      .ram_ctl   (ram_ctl),
      .pick      (pick),
      .status    (status)
   );

   // Output register: the valid bit follows the pick whenever the slot frees up.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = pick.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && pick.valid) begin
         value_ff       <= pick.value;
         from_second_ff <= pick.from_second;
         last_ff        <= pick.last;
         overflow_ff    <= pick.overflow;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = value_ff;
   assign rsp_from_second  = from_second_ff;
   assign rsp_last         = last_ff;
   assign rsp_overflow     = overflow_ff;

   // Neither fill count may pass the store capacity.
   `SSM_CHECK_NOW(a_count_bound, 1'b1,
                  (status.cnt_first <= DEPTH_CNT) && (status.cnt_second <= DEPTH_CNT),
                  "fill count beyond capacity")

   // While a merge runs, the read pointers never pass the fill counts.
   `SSM_CHECK_NOW(a_ptr_bound, status.busy,
                  (status.ptr_first <= status.cnt_first) &&
                  (status.ptr_second <= status.cnt_second),
                  "merge pointer beyond fill count")

   // Handing the final word to the output register ends the merge and empties both stores.
   `SSM_CHECK_NEXT(a_last_ends_merge, pick.valid && pick.last && out_free,
                   !status.busy && (status.cnt_first == '0) && (status.cnt_second == '0),
                   "merge did not finish after its final word")

endmodule
